// ===== hdl/bris_pkg.sv =====
// Shared types for the byte range interval set: operation and status codes,
// controller states, and the control and flag groups passed between the cells.
// No dependencies.
package bris_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_RANGE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CMP    = 5'b00010,
		S_UPD    = 5'b00100,
		S_SHRINK = 5'b01000,
		S_RES    = 5'b10000
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic cmp;       // classify each cell against the range
		logic upd;       // apply the operation (already gated by status)
		logic shrink;    // pull the chain left over one dead cell
		op_t  op;
		logic any_m;     // some cell overlaps or touches the range
		logic spl;       // remove splits one interval in two
		logic any_dead;  // the update leaves at least one dead cell
	} ctl_t;

	// Flags one cell shows to its neighbors and to the controller.
	typedef struct packed {
		logic m;        // insert: merges with range; remove: overlaps range
		logic a;        // lies wholly before the range
		logic kl;       // remove: part left of the range survives
		logic kr;       // remove: part right of the range survives
		logic hit;      // query: range lies inside this interval
		logic sel;      // read: this cell is the indexed entry
		logic dead;     // cell waits to be squeezed out
		logic dead_nx;  // cell becomes dead in the current update
	} flags_t;

endpackage

// ===== hdl/byte_range_interval_set_unit.sv =====
// Top level of the byte range interval set: controller, result register and
// the chain of interval cells. Depends on bris_pkg and bris_cell.
//
// The unit keeps a sorted set of disjoint inclusive byte ranges, one per cell
// of a chain of MAX_INTERVALS cells, and starts empty after reset. Each input
// beat carries one operation: insert merges a range into the set and joins
// every interval that overlaps or touches it, remove cuts a range out and
// splits an interval that strictly contains it, query reports whether the
// range lies inside a single stored interval, and read returns the interval
// at entry_index. Every input beat yields exactly one output beat holding the
// interval count after the operation and a status: ok, bad range when the end
// lies below the begin, or full when the table has no room, in which case the
// set is left unchanged. An accepted operation goes through the compare, update
// and result states back to idle when no stored interval has to be squeezed
// out. When an insert joins k + 1 stored intervals into one, or a remove
// swallows k intervals whole, a shrink state between update and result shifts
// the chain left by one cell per cycle until no dead cell is left; that shift,
// one position per cycle between neighboring cells, sets the cost. All cells
// compare against the range in parallel in the compare state, so the count
// of intervals does not bear on the time of query, read, or an insert or
// remove that squeezes nothing out. A finished result sits in the output
// register while the next beat is taken, so a stalled output holds the unit
// only once a second result is ready.
module byte_range_interval_set_unit #(
	parameter int MAX_INTERVALS = 64,
	parameter int OFFSET_BITS   = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       op,
	input  logic [OFFSET_BITS-1:0]           range_begin,
	input  logic [OFFSET_BITS-1:0]           range_end,
	input  logic [$clog2(MAX_INTERVALS)-1:0] entry_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [$clog2(MAX_INTERVALS+1)-1:0] interval_count,
	output logic                             hit,
	output logic                             entry_valid,
	output logic [OFFSET_BITS-1:0]           entry_begin,
	output logic [OFFSET_BITS-1:0]           entry_end,
	output logic [1:0]                       status
);
	import bris_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_INTERVALS + 1);
	localparam int IDX_BITS = $clog2(MAX_INTERVALS);

	state_t                 state_q;
	op_t                    op_q;
	logic [OFFSET_BITS-1:0] b_q, e_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic                   bad_q;
	logic [CNT_BITS-1:0]    count_q;
	status_t                status_q;

	logic                   out_valid_q;
	logic [CNT_BITS-1:0]    out_count_q;
	logic                   out_hit_q, out_ev_q;
	logic [OFFSET_BITS-1:0] out_lo_q, out_hi_q;
	status_t                out_status_q;

	flags_t                 cf [MAX_INTERVALS];
	logic [OFFSET_BITS-1:0] clo [MAX_INTERVALS];
	logic [OFFSET_BITS-1:0] chi [MAX_INTERVALS];

	ctl_t                   ctl;
	logic                   any_m, spl, any_dead_nx, any_dead_q, any_hit, any_sel;
	logic [OFFSET_BITS-1:0] rd_lo, rd_hi;
	logic                   full, modify, upd_en;

	// Reductions over the whole chain; each term comes from one cell.
	always_comb begin
		any_m       = 1'b0;
		spl         = 1'b0;
		any_dead_nx = 1'b0;
		any_dead_q  = 1'b0;
		any_hit     = 1'b0;
		any_sel     = 1'b0;
		rd_lo       = '0;
		rd_hi       = '0;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			any_m       = any_m | cf[i].m;
			spl         = spl | (cf[i].m & cf[i].kl & cf[i].kr);
			any_dead_nx = any_dead_nx | cf[i].dead_nx;
			any_dead_q  = any_dead_q | cf[i].dead;
			any_hit     = any_hit | cf[i].hit;
			any_sel     = any_sel | cf[i].sel;
			rd_lo       = rd_lo | (cf[i].sel ? clo[i] : '0);
			rd_hi       = rd_hi | (cf[i].sel ? chi[i] : '0);
		end
	end

	// A remove that would split an interval, or an insert that would need a
	// fresh interval, has nowhere to go once every cell is in use.
	assign full = (count_q == CNT_BITS'(MAX_INTERVALS)) &&
		(((op_q == OP_INSERT) && !any_m) || ((op_q == OP_REMOVE) && spl));
	assign modify = (op_q == OP_INSERT) || (op_q == OP_REMOVE);
	assign upd_en = (state_q == S_UPD) && modify && !bad_q && !full;

	// The dead flags only mean something while an update is applied, so
	// any_dead is driven from the update terms alone.
	always_comb begin
		ctl.cmp      = (state_q == S_CMP);
		ctl.upd      = upd_en;
		ctl.shrink   = (state_q == S_SHRINK) && any_dead_q;
		ctl.op       = op_q;
		ctl.any_m    = any_m;
		ctl.spl      = spl;
		ctl.any_dead = any_dead_nx;
	end

	for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
		flags_t                 pf, nf;
		logic [OFFSET_BITS-1:0] plo, phi, nlo, nhi;
		if (g == 0) begin : g_first
			assign pf  = '0;
			assign plo = '0;
			assign phi = '0;
		end else begin : g_mid
			assign pf  = cf[g-1];
			assign plo = clo[g-1];
			assign phi = chi[g-1];
		end
		if (g == MAX_INTERVALS - 1) begin : g_last
			assign nf  = '0;
			assign nlo = '0;
			assign nhi = '0;
		end else begin : g_inner
			assign nf  = cf[g+1];
			assign nlo = clo[g+1];
			assign nhi = chi[g+1];
		end
		bris_cell #(
			.OFFSET_BITS(OFFSET_BITS),
			.CNT_BITS   (CNT_BITS),
			.IDX_BITS   (IDX_BITS),
			.IDX        (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.b       (b_q),
			.e       (e_q),
			.count   (count_q),
			.rd_index(idx_q),
			.prev_f  (pf),
			.prev_lo (plo),
			.prev_hi (phi),
			.next_f  (nf),
			.next_lo (nlo),
			.next_hi (nhi),
			.f       (cf[g]),
			.lo      (clo[g]),
			.hi      (chi[g])
		);
	end

	assign in_stall = (state_q != S_IDLE);

	// Controller and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			bad_q       <= 1'b0;
			status_q    <= ST_OK;
			op_q        <= OP_READ;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if ((state_q == S_RES) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op_t'(op);
						bad_q   <= (op_t'(op) != OP_READ) && (range_end < range_begin);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					// Read never raises bad_q, so this covers insert, remove
					// and query alike.
					if (bad_q) begin
						status_q <= ST_BAD_RANGE;
					end else if (full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
					end
					// A fresh interval or a split adds one entry.
					if (upd_en && (((op_q == OP_INSERT) && !any_m) ||
							((op_q == OP_REMOVE) && spl))) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= (upd_en && any_dead_nx) ? S_SHRINK : S_RES;
				end
				S_SHRINK: begin
					if (any_dead_q) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			b_q   <= range_begin;
			e_q   <= range_end;
			idx_q <= entry_index;
		end
		if ((state_q == S_RES) && (!out_valid_q || !out_stall)) begin
			out_count_q  <= count_q;
			out_hit_q    <= (op_q == OP_QUERY) && !bad_q && any_hit;
			out_ev_q     <= (op_q == OP_READ) && any_sel;
			out_lo_q     <= (op_q == OP_READ) ? rd_lo : '0;
			out_hi_q     <= (op_q == OP_READ) ? rd_hi : '0;
			out_status_q <= status_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign interval_count = out_count_q;
	assign hit            = out_hit_q;
	assign entry_valid    = out_ev_q;
	assign entry_begin    = out_lo_q;
	assign entry_end      = out_hi_q;
	assign status         = out_status_q;

endmodule

// ===== hdl/bris_cell.sv =====
// One cell of the interval chain: holds one interval, classifies it against
// the current range and takes data from its left or right neighbor.
// Depends on bris_pkg.
module bris_cell #(
	parameter int OFFSET_BITS = 48,
	parameter int CNT_BITS    = 7,
	parameter int IDX_BITS    = 6,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bris_pkg::ctl_t         ctl,
	input  logic [OFFSET_BITS-1:0] b,
	input  logic [OFFSET_BITS-1:0] e,
	input  logic [CNT_BITS-1:0]    count,
	input  logic [IDX_BITS-1:0]    rd_index,
	input  bris_pkg::flags_t       prev_f,
	input  logic [OFFSET_BITS-1:0] prev_lo,
	input  logic [OFFSET_BITS-1:0] prev_hi,
	input  bris_pkg::flags_t       next_f,
	input  logic [OFFSET_BITS-1:0] next_lo,
	input  logic [OFFSET_BITS-1:0] next_hi,
	output bris_pkg::flags_t       f,
	output logic [OFFSET_BITS-1:0] lo,
	output logic [OFFSET_BITS-1:0] hi
);
	import bris_pkg::*;

	localparam bit IS_FIRST = (IDX == 0);

	logic [OFFSET_BITS-1:0] lo_q, hi_q;
	logic m_q, a_q, kl_q, kr_q, hit_q, sel_q, dead_q, sh_q, abs_q;

	logic                 occ;
	logic [OFFSET_BITS:0] hi_p1, e_p1;
	logic                 ins_a, ins_m, rem_a, rem_m;
	logic                 c_m, c_a, c_kl, c_kr, c_hit, c_sel;
	logic                 own_split, prev_split, first_m;
	logic                 dead_nx, rightish, sh_nx;

	assign occ   = count > CNT_BITS'(IDX);
	assign hi_p1 = {1'b0, hi_q} + 1'b1;
	assign e_p1  = {1'b0, e} + 1'b1;

	always_comb begin
		ins_a = occ && (hi_p1 < {1'b0, b});
		ins_m = occ && !ins_a && ({1'b0, lo_q} <= e_p1);
		rem_a = occ && (hi_q < b);
		rem_m = occ && !rem_a && !(lo_q > e);
		c_a   = (ctl.op == OP_INSERT) ? ins_a : rem_a;
		c_m   = (ctl.op == OP_INSERT) ? ins_m : rem_m;
		c_kl  = rem_m && (lo_q < b);
		c_kr  = rem_m && (hi_q > e);
		c_hit = occ && (lo_q <= b) && (e <= hi_q);
		c_sel = occ && (rd_index == IDX_BITS'(IDX));
	end

	always_comb begin
		own_split  = m_q && kl_q && kr_q;
		prev_split = prev_f.m && prev_f.kl && prev_f.kr;
		first_m    = m_q && !prev_f.m;
		if (ctl.op == OP_INSERT) begin
			dead_nx  = ctl.any_m && m_q && prev_f.m;
			rightish = !a_q && !m_q;
		end else begin
			dead_nx  = !ctl.spl && m_q && !kl_q && !kr_q;
			rightish = (!a_q && !m_q) || (m_q && kr_q && !kl_q);
		end
		sh_nx = ctl.any_dead && (dead_nx || rightish);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q    <= 1'b0;
			a_q    <= 1'b0;
			kl_q   <= 1'b0;
			kr_q   <= 1'b0;
			hit_q  <= 1'b0;
			sel_q  <= 1'b0;
			dead_q <= 1'b0;
			sh_q   <= 1'b0;
			abs_q  <= 1'b0;
		end else if (ctl.cmp) begin
			m_q    <= c_m;
			a_q    <= c_a;
			kl_q   <= c_kl;
			kr_q   <= c_kr;
			hit_q  <= c_hit;
			sel_q  <= c_sel;
			dead_q <= 1'b0;
			sh_q   <= 1'b0;
			abs_q  <= 1'b0;
		end else if (ctl.upd) begin
			dead_q <= dead_nx;
			sh_q   <= sh_nx;
			abs_q  <= (ctl.op == OP_INSERT) && first_m;
		end else if (ctl.shrink && sh_q) begin
			dead_q <= next_f.dead;
		end
	end

	// Interval contents carry no reset.
	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (ctl.op == OP_INSERT) begin
				if (!ctl.any_m) begin
					if (!a_q) begin
						if (IS_FIRST || prev_f.a) begin
							lo_q <= b;
							hi_q <= e;
						end else begin
							lo_q <= prev_lo;
							hi_q <= prev_hi;
						end
					end
				end else if (first_m) begin
					lo_q <= (lo_q < b) ? lo_q : b;
					hi_q <= (hi_q > e) ? hi_q : e;
				end
			end else if (ctl.spl) begin
				if (own_split) begin
					hi_q <= b - 1'b1;
				end else if (prev_split) begin
					lo_q <= e_p1[OFFSET_BITS-1:0];
					hi_q <= prev_hi;
				end else if (!a_q) begin
					lo_q <= prev_lo;
					hi_q <= prev_hi;
				end
			end else if (m_q) begin
				if (kl_q) begin
					hi_q <= b - 1'b1;
				end
				if (kr_q) begin
					lo_q <= e_p1[OFFSET_BITS-1:0];
				end
			end
		end else if (ctl.shrink) begin
			if (sh_q) begin
				lo_q <= next_lo;
				hi_q <= next_hi;
			end else if (abs_q && next_f.dead && (next_hi > hi_q)) begin
				hi_q <= next_hi;
			end
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;
	assign f  = '{m: m_q, a: a_q, kl: kl_q, kr: kr_q, hit: hit_q, sel: sel_q,
		dead: dead_q, dead_nx: dead_nx};

endmodule
